// ----- rtl/kvhie_pkg.sv -----
// Shared types and constants of the key-value hash index engine.
package kvhie_pkg;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_PEEK = 2'd2,
    OP_TAKE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_NOKEY = 2'd2
  } status_e;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_MAX_KEYS = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN  = 2'd2;

  localparam logic [31:0] RST_CAPACITY = 32'd1048576;
  localparam logic [10:0] RST_MAX_KEYS = 11'd1024;
  localparam logic [31:0] RST_MAX_LEN  = 32'd4096;

  localparam logic [31:0] MIX_MUL1 = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL2 = 32'h846ca68b;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] lba;
    logic [31:0] length;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic        issue_valid;
    logic        issue_write;
    logic [31:0] issue_lba;
    logic [15:0] issue_tag;
    logic        completion_pending;
    logic [31:0] completion_length;
  } result_t;

endpackage

// ----- rtl/kv_hash_index_engine_core.sv -----
// Top level of the key-value hash index engine: sequencer, probe walk, tables and ports.
// One item at a time. After reset a clearing pass zeroes the entry table and the
// pending-completion table; no item is taken meanwhile (configuration writes are). A put
// or get runs the key hash, then a probe walk in which each probe is one read of the
// entry table, then a decide step, before the next item can be accepted; the
// reciprocal-multiply home-index reduction is used only when TABLE_ENTRIES is not a power
// of two. The hash multiplier is shared over both mix rounds and the reduction. Peek and
// take each read the pending-completion table. A finished result waits
// in an output register while the next item is accepted; the following result is held
// until the output register is free.
module kv_hash_index_engine_core #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned CMD_SLOTS     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] slot_tag_i,
  input  logic [31:0] key_i,
  input  logic [31:0] length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        issue_valid_o,
  output logic        issue_write_o,
  output logic [31:0] issue_lba_o,
  output logic [15:0] issue_tag_o,
  output logic        completion_pending_o,
  output logic [31:0] completion_length_o
);
  import kvhie_pkg::*;

  localparam int unsigned IW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned PW    = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;
  localparam int unsigned CLR_N = (TABLE_ENTRIES > CMD_SLOTS) ? TABLE_ENTRIES : CMD_SLOTS;
  localparam int unsigned CW    = $clog2(CLR_N) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_DECIDE, S_PEND_RD, S_PEND_CHK, S_RESP
  } state_e;

  state_e        state_q;
  logic [CW-1:0] clr_q;
  logic [31:0]   cap_q, maxlen_q, nfl_q, nfl_d;
  logic [10:0]   maxkeys_q, cnt_q, cnt_d;
  op_e           op_q;
  logic [15:0]   tag_q;
  logic [31:0]   key_q, len_q;
  logic [IW-1:0] pos_q;
  logic [IW:0]   n_q;
  logic          found_q, hit_q;
  entry_t        ent_q;
  result_t       res_q, dec_res, out_q;
  logic          out_valid_q;

  logic          in_acc;
  logic          hash_done;
  logic [IW-1:0] hash_idx;
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  entry_t        tbl_wdata, tbl_rdata;
  logic          pend_we;
  logic [PW-1:0] pend_waddr, tag_idx;
  logic [31:0]   pend_wdata, pend_rdata;
  logic          tag_ok, pend_hit;
  logic          is_empty, is_match;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign tag_idx     = tag_q[PW-1:0];
  assign tag_ok      = {1'b0, tag_q} < 17'(CMD_SLOTS);
  assign pend_hit    = tag_ok && (pend_rdata != 32'd0);
  assign is_empty    = (tbl_rdata.length == 32'd0);
  assign is_match    = (tbl_rdata.key == key_q);

  kvhie_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (op_i == OP_PUT || op_i == OP_GET)),
    .key_i   (key_i),
    .done_o  (hash_done),
    .index_o (hash_idx)
  );

  kvhie_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES), .AW(IW)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (pos_q),
    .rdata_o (tbl_rdata)
  );

  kvhie_ram #(.WIDTH(32), .DEPTH(CMD_SLOTS), .AW(PW)) u_pending (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (tag_idx),
    .rdata_o (pend_rdata)
  );

  always_comb begin
    dec_res    = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = pos_q;
    tbl_wdata  = '0;
    pend_we    = 1'b0;
    pend_waddr = tag_idx;
    pend_wdata = '0;
    nfl_d      = nfl_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      S_CLEAR: begin
        tbl_we     = clr_q < CW'(TABLE_ENTRIES);
        tbl_waddr  = clr_q[IW-1:0];
        pend_we    = clr_q < CW'(CMD_SLOTS);
        pend_waddr = clr_q[PW-1:0];
      end
      S_DECIDE: begin
        if (op_q == OP_PUT) begin
          if (len_q > maxlen_q || !found_q) begin
            dec_res.status = ST_ERR;
          end else if (!hit_q && (nfl_q >= cap_q || cnt_q >= maxkeys_q)) begin
            dec_res.status = ST_ERR;
          end else begin
            dec_res.status      = ST_OK;
            dec_res.issue_valid = 1'b1;
            dec_res.issue_write = 1'b1;
            dec_res.issue_lba   = hit_q ? ent_q.lba : nfl_q;
            dec_res.issue_tag   = tag_q;
            tbl_we              = 1'b1;
            tbl_wdata.key       = key_q;
            tbl_wdata.lba       = dec_res.issue_lba;
            tbl_wdata.length    = len_q;
            if (!hit_q) begin
              nfl_d = nfl_q + 32'd1;
              cnt_d = cnt_q + 11'd1;
            end
          end
        end else begin
          if (!found_q || !hit_q) begin
            dec_res.status = ST_NOKEY;
          end else if (len_q < ent_q.length || !tag_ok) begin
            dec_res.status = ST_ERR;
          end else begin
            dec_res.status      = ST_OK;
            dec_res.issue_valid = 1'b1;
            dec_res.issue_lba   = ent_q.lba;
            dec_res.issue_tag   = tag_q;
            pend_we             = 1'b1;
            pend_wdata          = ent_q.length;
          end
        end
      end
      S_PEND_CHK: begin
        dec_res.status             = ST_OK;
        dec_res.completion_pending = pend_hit;
        if (op_q == OP_TAKE && pend_hit) begin
          dec_res.completion_length = pend_rdata;
          pend_we                   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cap_q       <= RST_CAPACITY;
      maxkeys_q   <= RST_MAX_KEYS;
      maxlen_q    <= RST_MAX_LEN;
      nfl_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_PUT;
      tag_q       <= '0;
      key_q       <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      ent_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CAPACITY: cap_q     <= cfg_data_i;
          CFG_MAX_KEYS: maxkeys_q <= cfg_data_i[10:0];
          CFG_MAX_LEN:  maxlen_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      nfl_q <= nfl_d;
      cnt_q <= cnt_d;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= op_e'(op_i);
            tag_q   <= slot_tag_i;
            key_q   <= key_i;
            len_q   <= length_i;
            state_q <= (op_i == OP_PUT || op_i == OP_GET) ? S_HASH : S_PEND_RD;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pos_q   <= hash_idx;
            n_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          ent_q <= tbl_rdata;
          if (is_empty || is_match) begin
            found_q <= 1'b1;
            hit_q   <= !is_empty;
            state_q <= S_DECIDE;
          end else if (n_q == (IW + 1)'(TABLE_ENTRIES - 1)) begin
            found_q <= 1'b0;
            hit_q   <= 1'b0;
            state_q <= S_DECIDE;
          end else begin
            n_q     <= n_q + (IW + 1)'(1);
            pos_q   <= (pos_q == IW'(TABLE_ENTRIES - 1)) ? '0 : pos_q + IW'(1);
            state_q <= S_RD;
          end
        end
        S_DECIDE: begin
          res_q   <= dec_res;
          state_q <= S_RESP;
        end
        S_PEND_RD: begin
          state_q <= S_PEND_CHK;
        end
        S_PEND_CHK: begin
          res_q   <= dec_res;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign issue_valid_o        = out_q.issue_valid;
  assign issue_write_o        = out_q.issue_write;
  assign issue_lba_o          = out_q.issue_lba;
  assign issue_tag_o          = out_q.issue_tag;
  assign completion_pending_o = out_q.completion_pending;
  assign completion_length_o  = out_q.completion_length;

`ifndef SYNTH
  a_load_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result loaded outside response state");
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> state_q == S_HASH)
    else $error("hash finished while sequencer not waiting");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CHK) |-> n_q < (IW + 1)'(TABLE_ENTRIES))
    else $error("probe walk ran past table size");
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.issue_valid) |-> out_q.status == ST_OK)
    else $error("flash request issued with failing status");
`endif

endmodule

// ----- rtl/kvhie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kvhie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/kvhie_hash.sv -----
// Iterative xorshift-multiply key hash with one shared multiplier and home index reduction.
module kvhie_hash #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  localparam int unsigned IW = $clog2(TABLE_ENTRIES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   key_i,
  output logic          done_o,
  output logic [IW-1:0] index_o
);
  import kvhie_pkg::*;

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [31:0] MODULUS = 32'(TABLE_ENTRIES);
  // floor(2^32 / TABLE_ENTRIES): quotient estimate is exact or one low
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_ENTRIES));

  typedef enum logic [2:0] {
    H_IDLE, H_MUL1, H_MUL2, H_QUO, H_PROD, H_SUB, H_FIX, H_DONE
  } hstate_e;

  hstate_e       st_q;
  logic [31:0]   x_q;
  logic [31:0]   q_q;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod_w;
  logic [31:0]   prod;

  always_comb begin
    mul_a = x_q;
    mul_b = MIX_MUL2;
    unique case (st_q)
      H_MUL1: mul_b = MIX_MUL1;
      H_QUO:  mul_b = RECIP;
      H_PROD: begin
        mul_a = q_q;
        mul_b = MODULUS;
      end
      default: begin
      end
    endcase
  end

  assign prod_w = {32'd0, mul_a} * {32'd0, mul_b};
  assign prod   = prod_w[31:0];

  assign done_o  = (st_q == H_DONE);
  assign index_o = x_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= H_IDLE;
      x_q  <= '0;
      q_q  <= '0;
    end else begin
      unique case (st_q)
        H_IDLE: begin
          if (start_i) begin
            x_q  <= key_i ^ (key_i >> 16);
            st_q <= H_MUL1;
          end
        end
        H_MUL1: begin
          x_q  <= prod ^ (prod >> 15);
          st_q <= H_MUL2;
        end
        H_MUL2: begin
          x_q  <= prod ^ (prod >> 16);
          st_q <= IS_POW2 ? H_DONE : H_QUO;
        end
        H_QUO: begin
          q_q  <= prod_w[63:32];
          st_q <= H_PROD;
        end
        H_PROD: begin
          q_q  <= prod;
          st_q <= H_SUB;
        end
        H_SUB: begin
          x_q  <= x_q - q_q;
          st_q <= H_FIX;
        end
        H_FIX: begin
          if (x_q >= MODULUS) begin
            x_q <= x_q - MODULUS;
          end
          st_q <= H_DONE;
        end
        H_DONE: begin
          st_q <= H_IDLE;
        end
        default: begin
          st_q <= H_IDLE;
        end
      endcase
    end
  end

endmodule
